[sv/line_tracker_course_fsm_defines.svh]
// ---------------------------------------------------------------------------
// Line tracker course FSM assertion macros
// Shared macros for the concurrent checks attached to the block.
// ---------------------------------------------------------------------------
`ifndef LINE_TRACKER_COURSE_FSM_DEFINES_SVH
`define LINE_TRACKER_COURSE_FSM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define LCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line tracker check failed");

`endif

[sv/lct_pkg.sv]
// ---------------------------------------------------------------------------
// Line tracker course FSM package
// Widths, mode codes, register indexes, course constants and shared types.
// ---------------------------------------------------------------------------
package lct_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SAMPLE_W    = 10;
  localparam int CNT_W       = $clog2(NUM_SENSORS + 1);
  localparam int SUM_W       = 13;
  localparam int WSUM_W      = 15;
  localparam int DIFF_W      = 17;
  localparam int GAIN_W      = 11;
  localparam int PROD_W      = 27;
  localparam int MAG_W       = 26;
  localparam int DEN_W       = 14;
  localparam int QUO_W       = 12;
  localparam int STEER_W     = 13;
  localparam int SPEED_W     = 6;
  localparam int MODE_W      = 3;
  localparam int CFG_W       = 16;
  localparam int REG_IDX_W   = 3;

  localparam logic [MODE_W-1:0] MODE_FOLLOW       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CORNER_IN    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CORNER_OUT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT_DETECT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RIGHT_TURN   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LEFT_DETECT  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LEFT_TURN    = 3'd6;

  localparam logic [REG_IDX_W-1:0] REG_DARK_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CORNER_COUNT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANGE_COUNT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAP_TICKS      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CORNER_OUT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CHANGE_TIMEOUT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TURN_HOLD      = 3'd6;

  localparam logic [SPEED_W-1:0] SPEED_FAST = 6'd40;
  localparam logic [SPEED_W-1:0] SPEED_SLOW = 6'd20;

  localparam logic [GAIN_W-1:0] GAIN_HIGH = 11'd1000;
  localparam logic [GAIN_W-1:0] GAIN_LOW  = 11'd100;

  localparam logic signed [STEER_W-1:0] STEER_HARD  = 13'sd25;
  localparam logic signed [STEER_W-1:0] STEER_SOFT  = 13'sd5;
  localparam logic [QUO_W:0]            STEER_LIMIT = 13'd4095;

  localparam logic [DIFF_W-1:0] CENTER_SPAN    = DIFF_W'(NUM_SENSORS - 1);
  localparam logic [CNT_W-1:0]  TURN_EXIT_DARK = CNT_W'(2);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [WSUM_W-1:0]   weighted;
    logic                dark;
    logic                left;
    logic                right;
  } lane_t;

  typedef struct packed {
    logic [WSUM_W-1:0] wsum;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  dark;
    logic [CNT_W-1:0]  left;
    logic [CNT_W-1:0]  right;
  } sums_t;

endpackage

[sv/lct_lane.sv]
// ---------------------------------------------------------------------------
// Line tracker sensor lane
// Weights one sample by its position and classifies it as dark or not.
// ---------------------------------------------------------------------------
module lct_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic [lct_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [lct_pkg::SAMPLE_W-1:0] threshold_i,
  output lct_pkg::lane_t               lane_o
);

  localparam logic [lct_pkg::WSUM_W-1:0] IDX = lct_pkg::WSUM_W'(LANE_IDX);
  localparam logic IS_LEFT = (LANE_IDX < lct_pkg::NUM_SENSORS / 2);

  logic dark;

  assign dark            = sample_i < threshold_i;
  assign lane_o.sample   = sample_i;
  assign lane_o.weighted = lct_pkg::WSUM_W'(sample_i) * IDX;
  assign lane_o.dark     = dark;
  assign lane_o.left     = dark & IS_LEFT;
  assign lane_o.right    = dark & ~IS_LEFT;

endmodule

[sv/lct_merge.sv]
// ---------------------------------------------------------------------------
// Line tracker lane merge
// Adds the lane results into registered sums and dark counts.
// ---------------------------------------------------------------------------
module lct_merge (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  lct_pkg::lane_t [lct_pkg::NUM_SENSORS-1:0] lanes_i,
  output lct_pkg::sums_t        sums_o
);

  lct_pkg::sums_t sums_d;
  lct_pkg::sums_t sums_q;

  always_comb begin
    sums_d = '0;
    for (int i = 0; i < lct_pkg::NUM_SENSORS; i++) begin
      sums_d.wsum  = sums_d.wsum + lanes_i[i].weighted;
      sums_d.sum   = sums_d.sum + lct_pkg::SUM_W'(lanes_i[i].sample);
      sums_d.dark  = sums_d.dark + lct_pkg::CNT_W'(lanes_i[i].dark);
      sums_d.left  = sums_d.left + lct_pkg::CNT_W'(lanes_i[i].left);
      sums_d.right = sums_d.right + lct_pkg::CNT_W'(lanes_i[i].right);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

[sv/lct_div.sv]
// ---------------------------------------------------------------------------
// Line tracker steering divider
// Restoring divider that yields one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lct_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lct_pkg::MAG_W-1:0]   mag_i,
  input  logic [lct_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [lct_pkg::QUO_W-1:0]   quo_o
);

  localparam int QW    = lct_pkg::QUO_W;
  localparam int DW    = lct_pkg::DEN_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    low_q;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem_q, low_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(mag_i >> QW);
      low_q <= mag_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = low_q;

endmodule

[sv/line_tracker_course_fsm.sv]
// ---------------------------------------------------------------------------
// Line tracker course FSM
// Centroid steering and seven-mode course control for one control tick.
// ---------------------------------------------------------------------------
// The input channel carries one transaction per control tick: eight
// reflectance samples, sensor 0 leftmost. The output channel returns one
// transaction per tick with drive speed, steering value and the mode the
// tick acted in. Both channels use valid and stall.
// One transaction is in work at a time. From acceptance to the result
// register it passes the lane compare, weighting and merge adder, the
// gained offset, its magnitude and saturation check while the divider
// loads, the divider at one quotient bit per cycle, the divider's done
// flag, then the result cycle. The input is stalled while a transaction
// is in work, so a new transaction is accepted only once the previous
// one has left its result cycle.
// A held output stalls the block in its result cycle, and mode and tick
// count advance only when the result enters the output register.
// Reset sets follow mode, clears the tick count and loads the default
// thresholds and tick limits. The APB port writes and reads the seven
// configuration registers at byte addresses 0 to 24.
module line_tracker_course_fsm #(
  parameter int TICK_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_0_i,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_1_i,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_2_i,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_3_i,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_4_i,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_5_i,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_6_i,
  input  logic [lct_pkg::SAMPLE_W-1:0]         sample_7_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lct_pkg::SPEED_W-1:0]          drive_speed_o,
  output logic signed [lct_pkg::STEER_W-1:0]   steer_value_o,
  output logic [lct_pkg::MODE_W-1:0]           mode_out_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [4:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  localparam int NS    = lct_pkg::NUM_SENSORS;
  localparam int SW    = lct_pkg::SAMPLE_W;
  localparam int CW    = lct_pkg::CFG_W;
  localparam int EXT_W = (TICK_BITS > CW) ? TICK_BITS : CW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  logic [SW-1:0] dark_thr_q;
  logic [3:0]    corner_cnt_q;
  logic [2:0]    change_cnt_q;
  logic [CW-1:0] gap_q;
  logic [CW-1:0] corner_out_q;
  logic [CW-1:0] timeout_q;
  logic [CW-1:0] turn_hold_q;
  logic          cfg_wr;

  logic [lct_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [TICK_BITS-1:0]       elapsed_q, elapsed_d;

  logic [NS-1:0][SW-1:0]           sample_q;
  lct_pkg::lane_t [NS-1:0]         lanes;
  lct_pkg::sums_t                  sums;

  logic signed [lct_pkg::DIFF_W-1:0] diff;
  logic signed [lct_pkg::GAIN_W-1:0] gain;
  logic signed [lct_pkg::PROD_W-1:0] prod_q;
  logic [lct_pkg::DEN_W-1:0]         den_q;
  logic                              zero_q;
  logic [lct_pkg::MAG_W-1:0]         mag;
  logic                              neg_q;
  logic                              sat_q;
  logic                              div_done;
  logic [lct_pkg::QUO_W-1:0]         quo;
  logic [lct_pkg::QUO_W:0]           qmag;
  logic signed [lct_pkg::STEER_W-1:0] gained;

  logic [TICK_BITS-1:0] inc;
  logic [EXT_W-1:0]     inc_x;
  logic                 gap_ok;
  logic [lct_pkg::CNT_W-1:0] chg;
  logic                 go;
  logic                 out_free;
  logic                 emit;

  logic                                out_valid_q;
  logic [lct_pkg::SPEED_W-1:0]         speed_q, speed_d;
  logic signed [lct_pkg::STEER_W-1:0]  steer_q, steer_d;
  logic [lct_pkg::MODE_W-1:0]          acted_q;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_thr_q   <= SW'(400);
      corner_cnt_q <= 4'd6;
      change_cnt_q <= 3'd3;
      gap_q        <= CW'(20);
      corner_out_q <= CW'(50);
      timeout_q    <= CW'(150);
      turn_hold_q  <= CW'(40);
    end else if (cfg_wr) begin
      case (paddr[4:2])
        lct_pkg::REG_DARK_THRESHOLD: dark_thr_q   <= pwdata[SW-1:0];
        lct_pkg::REG_CORNER_COUNT:   corner_cnt_q <= pwdata[3:0];
        lct_pkg::REG_CHANGE_COUNT:   change_cnt_q <= pwdata[2:0];
        lct_pkg::REG_GAP_TICKS:      gap_q        <= pwdata[CW-1:0];
        lct_pkg::REG_CORNER_OUT:     corner_out_q <= pwdata[CW-1:0];
        lct_pkg::REG_CHANGE_TIMEOUT: timeout_q    <= pwdata[CW-1:0];
        lct_pkg::REG_TURN_HOLD:      turn_hold_q  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lct_pkg::REG_DARK_THRESHOLD: prdata = 32'(dark_thr_q);
      lct_pkg::REG_CORNER_COUNT:   prdata = 32'(corner_cnt_q);
      lct_pkg::REG_CHANGE_COUNT:   prdata = 32'(change_cnt_q);
      lct_pkg::REG_GAP_TICKS:      prdata = 32'(gap_q);
      lct_pkg::REG_CORNER_OUT:     prdata = 32'(corner_out_q);
      lct_pkg::REG_CHANGE_TIMEOUT: prdata = 32'(timeout_q);
      lct_pkg::REG_TURN_HOLD:      prdata = 32'(turn_hold_q);
      default:                     prdata = '0;
    endcase
  end

  // Sample capture and sensor lanes.
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      sample_q[0] <= sample_0_i;
      sample_q[1] <= sample_1_i;
      sample_q[2] <= sample_2_i;
      sample_q[3] <= sample_3_i;
      sample_q[4] <= sample_4_i;
      sample_q[5] <= sample_5_i;
      sample_q[6] <= sample_6_i;
      sample_q[7] <= sample_7_i;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_lane
    lct_lane #(
      .LANE_IDX(g)
    ) u_lane (
      .sample_i   (sample_q[g]),
      .threshold_i(dark_thr_q),
      .lane_o     (lanes[g])
    );
  end

  lct_merge u_merge (
    .clk_i  (clk_i),
    .load_i (state_q == ST_SUM),
    .lanes_i(lanes),
    .sums_o (sums)
  );

  // Gained centroid offset, then its magnitude and saturation check.
  assign diff = $signed(lct_pkg::DIFF_W'({sums.wsum, 1'b0}))
              - $signed(lct_pkg::DIFF_W'(sums.sum) * lct_pkg::CENTER_SPAN);
  assign gain = (mode_q == lct_pkg::MODE_RIGHT_DETECT || mode_q == lct_pkg::MODE_LEFT_DETECT)
              ? $signed(lct_pkg::GAIN_LOW) : $signed(lct_pkg::GAIN_HIGH);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      prod_q <= lct_pkg::PROD_W'(diff) * lct_pkg::PROD_W'(gain);
      den_q  <= lct_pkg::DEN_W'({sums.sum, 1'b0});
      zero_q <= (sums.sum == '0);
    end
    if (state_q == ST_CHK) begin
      neg_q <= prod_q[lct_pkg::PROD_W-1];
      sat_q <= lct_pkg::PROD_W'(mag) >= {1'b0, den_q, {lct_pkg::QUO_W{1'b0}}};
    end
  end

  assign mag = prod_q[lct_pkg::PROD_W-1] ? lct_pkg::MAG_W'(-prod_q)
                                         : lct_pkg::MAG_W'(prod_q);

  lct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_CHK),
    .mag_i  (mag),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign qmag   = sat_q ? lct_pkg::STEER_LIMIT : {1'b0, quo};
  assign gained = zero_q ? '0
                : (neg_q ? -$signed(lct_pkg::STEER_W'(qmag)) : $signed(lct_pkg::STEER_W'(qmag)));

  // Course state machine.
  assign inc    = (&elapsed_q) ? elapsed_q : elapsed_q + TICK_BITS'(1);
  assign inc_x  = EXT_W'(inc);
  assign gap_ok = inc_x > EXT_W'(gap_q);
  assign chg    = lct_pkg::CNT_W'(change_cnt_q);

  always_comb begin
    mode_d  = mode_q;
    go      = 1'b0;
    steer_d = gained;
    speed_d = (mode_q == lct_pkg::MODE_FOLLOW || mode_q > lct_pkg::MODE_LEFT_TURN)
            ? lct_pkg::SPEED_FAST : lct_pkg::SPEED_SLOW;
    case (mode_q)
      lct_pkg::MODE_CORNER_IN: begin
        if (gap_ok && (sums.left > chg || sums.right > chg)) begin
          mode_d = lct_pkg::MODE_CORNER_OUT;
          go     = 1'b1;
        end
      end
      lct_pkg::MODE_CORNER_OUT: begin
        if (inc_x > EXT_W'(corner_out_q)) begin
          mode_d = lct_pkg::MODE_FOLLOW;
          go     = 1'b1;
        end
      end
      lct_pkg::MODE_RIGHT_DETECT, lct_pkg::MODE_LEFT_DETECT: begin
        if (sums.dark == '0) begin
          mode_d = (mode_q == lct_pkg::MODE_RIGHT_DETECT) ? lct_pkg::MODE_RIGHT_TURN
                                                          : lct_pkg::MODE_LEFT_TURN;
          go     = 1'b1;
        end else if (inc_x > EXT_W'(timeout_q)) begin
          mode_d = lct_pkg::MODE_FOLLOW;
          go     = 1'b1;
        end
      end
      lct_pkg::MODE_RIGHT_TURN: begin
        steer_d = (inc_x < EXT_W'(turn_hold_q)) ? -lct_pkg::STEER_HARD : lct_pkg::STEER_SOFT;
        if (sums.dark > lct_pkg::TURN_EXIT_DARK) begin
          mode_d = lct_pkg::MODE_FOLLOW;
          go     = 1'b1;
        end
      end
      lct_pkg::MODE_LEFT_TURN: begin
        steer_d = (inc_x < EXT_W'(turn_hold_q)) ? lct_pkg::STEER_HARD : -lct_pkg::STEER_SOFT;
        if (sums.dark > lct_pkg::TURN_EXIT_DARK) begin
          mode_d = lct_pkg::MODE_FOLLOW;
          go     = 1'b1;
        end
      end
      default: begin
        if (sums.dark > lct_pkg::CNT_W'(corner_cnt_q)) begin
          mode_d = lct_pkg::MODE_CORNER_IN;
          go     = 1'b1;
        end else if (gap_ok && sums.right > chg) begin
          mode_d = lct_pkg::MODE_RIGHT_DETECT;
          go     = 1'b1;
        end else if (gap_ok && sums.left > chg) begin
          mode_d = lct_pkg::MODE_LEFT_DETECT;
          go     = 1'b1;
        end
      end
    endcase
    elapsed_d = go ? '0 : inc;
  end

  // Sequencer.
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign emit     = (state_q == ST_DONE) & out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SUM;
      ST_SUM:  state_d = ST_PREP;
      ST_PREP: state_d = ST_CHK;
      ST_CHK:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= lct_pkg::MODE_FOLLOW;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        mode_q      <= mode_d;
        elapsed_q   <= elapsed_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      speed_q <= speed_d;
      steer_q <= steer_d;
      acted_q <= mode_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_speed_o = speed_q;
  assign steer_value_o = steer_q;
  assign mode_out_o    = acted_q;

endmodule

[sv/lct_checker.sv]
// ---------------------------------------------------------------------------
// Line tracker course FSM checker
// Port-level checks on results and handshakes, bound to the top level.
// ---------------------------------------------------------------------------
`include "line_tracker_course_fsm_defines.svh"

module lct_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [lct_pkg::SPEED_W-1:0]        drive_speed_o,
  input logic signed [lct_pkg::STEER_W-1:0] steer_value_o,
  input logic [lct_pkg::MODE_W-1:0]         mode_out_o
);

  logic follow_like;

  assign follow_like = (mode_out_o == lct_pkg::MODE_FOLLOW)
                     || (mode_out_o > lct_pkg::MODE_LEFT_TURN);

  `LCT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(steer_value_o) && $stable(mode_out_o) && $stable(drive_speed_o))

  `LCT_ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `LCT_ASSERT_NOW(a_speed_mode, clk_i, rst_ni, out_valid_o, (drive_speed_o == lct_pkg::SPEED_FAST) == follow_like)

  `LCT_ASSERT_NOW(a_right_turn_steer, clk_i, rst_ni, out_valid_o && mode_out_o == lct_pkg::MODE_RIGHT_TURN, steer_value_o == -lct_pkg::STEER_HARD || steer_value_o == lct_pkg::STEER_SOFT)

  `LCT_ASSERT_NOW(a_steer_range, clk_i, rst_ni, out_valid_o, steer_value_o >= -13'sd4095 && steer_value_o <= 13'sd4095)

endmodule

bind line_tracker_course_fsm lct_checker u_lct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .drive_speed_o(drive_speed_o),
  .steer_value_o(steer_value_o),
  .mode_out_o   (mode_out_o)
);

[verif/tb_line_tracker_course_fsm.sv]
// ---------------------------------------------------------------------------
// Line tracker course FSM testbench
// Feeds control ticks of eight reflectance samples through the valid/stall
// input channel, predicts speed, steering and mode of every tick in a
// course model kept inside the bench, and checks every output transaction
// field by field. Registers are rewritten over the APB port between phases.
// The phases are directed course laps, register extremes, random laps with
// random idling on both sides, a long output hold-off, and a walk into one
// turn that stays there past its hard steering stretch.
// ---------------------------------------------------------------------------
module tb_line_tracker_course_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AGE_W     = 16;
  localparam int RUN_LIMIT = 500000;
  localparam int SETTLE    = 24;
  localparam int LONG_HOLD = 300;

  typedef logic [lct_pkg::NUM_SENSORS-1:0][lct_pkg::SAMPLE_W-1:0] tick_samples_t;

  typedef enum int {
    TK_LINE, TK_BRIGHT, TK_CORNER, TK_RIGHT_MARK, TK_LEFT_MARK,
    TK_EXIT, TK_NOISE, TK_ZERO, TK_FULL
  } tick_kind_e;

  typedef struct {
    logic [lct_pkg::SPEED_W-1:0]        speed;
    logic signed [lct_pkg::STEER_W-1:0] steer;
    logic [lct_pkg::MODE_W-1:0]         mode;
  } course_result_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_0_i = '0;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_1_i = '0;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_2_i = '0;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_3_i = '0;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_4_i = '0;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_5_i = '0;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_6_i = '0;
  logic [lct_pkg::SAMPLE_W-1:0]        sample_7_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [lct_pkg::SPEED_W-1:0]         drive_speed_o;
  logic signed [lct_pkg::STEER_W-1:0]  steer_value_o;
  logic [lct_pkg::MODE_W-1:0]          mode_out_o;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [4:0]                          paddr = '0;
  logic [31:0]                         pwdata = '0;
  logic [31:0]                         prdata;
  logic                                pready;

  // Register copies and course state of the predictor.
  logic [lct_pkg::SAMPLE_W-1:0] cfg_thr = 10'd400;
  logic [3:0]                   cfg_corner = 4'd6;
  logic [2:0]                   cfg_change = 3'd3;
  logic [AGE_W-1:0]             cfg_gap = 16'd20;
  logic [AGE_W-1:0]             cfg_corner_out = 16'd50;
  logic [AGE_W-1:0]             cfg_timeout = 16'd150;
  logic [AGE_W-1:0]             cfg_hold = 16'd40;
  logic [lct_pkg::MODE_W-1:0]   pred_mode = lct_pkg::MODE_FOLLOW;
  logic [AGE_W-1:0]             pred_age = '0;

  tick_samples_t  tick_q[$];
  course_result_t course_exp_q[$];

  int offered_cnt = 0;
  int accepted_cnt = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_cnt = 0;

  line_tracker_course_fsm #(
    .TICK_BITS(AGE_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_0_i    (sample_0_i),
    .sample_1_i    (sample_1_i),
    .sample_2_i    (sample_2_i),
    .sample_3_i    (sample_3_i),
    .sample_4_i    (sample_4_i),
    .sample_5_i    (sample_5_i),
    .sample_6_i    (sample_6_i),
    .sample_7_i    (sample_7_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_speed_o (drive_speed_o),
    .steer_value_o (steer_value_o),
    .mode_out_o    (mode_out_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99, 0) >= pct) return 0;
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic int capped(input int x, input int cap);
    return (x > cap) ? cap : x;
  endfunction

  function automatic longint offset_steer(input longint gain, input longint wsum,
                                          input longint sum);
    longint q;
    if (sum == 0) return 0;
    q = gain * (2 * wsum - longint'(lct_pkg::NUM_SENSORS - 1) * sum) / (2 * sum);
    if (q > longint'(lct_pkg::STEER_LIMIT)) q = longint'(lct_pkg::STEER_LIMIT);
    if (q < -longint'(lct_pkg::STEER_LIMIT)) q = -longint'(lct_pkg::STEER_LIMIT);
    return q;
  endfunction

  function automatic void switch_mode(input logic [lct_pkg::MODE_W-1:0] m);
    pred_mode = m;
    pred_age = '0;
  endfunction

  function automatic course_result_t predict_tick(input tick_samples_t smp);
    course_result_t res;
    longint wsum, sum, steer;
    int dark, left_dark, right_dark;
    logic gap_ok;
    wsum = 0;
    sum = 0;
    steer = 0;
    dark = 0;
    left_dark = 0;
    right_dark = 0;
    for (int i = 0; i < lct_pkg::NUM_SENSORS; i++) begin
      wsum += longint'(smp[i]) * i;
      sum += longint'(smp[i]);
      if (smp[i] < cfg_thr) begin
        dark++;
        if (i < lct_pkg::NUM_SENSORS / 2) left_dark++;
        else right_dark++;
      end
    end
    if (pred_age != '1) pred_age++;
    gap_ok = pred_age > cfg_gap;
    res.mode = pred_mode;
    res.speed = (pred_mode == lct_pkg::MODE_FOLLOW || pred_mode > lct_pkg::MODE_LEFT_TURN) ?
                lct_pkg::SPEED_FAST : lct_pkg::SPEED_SLOW;
    case (pred_mode)
      lct_pkg::MODE_CORNER_IN: begin
        steer = offset_steer(longint'(lct_pkg::GAIN_HIGH), wsum, sum);
        if (gap_ok && (left_dark > cfg_change || right_dark > cfg_change))
          switch_mode(lct_pkg::MODE_CORNER_OUT);
      end
      lct_pkg::MODE_CORNER_OUT: begin
        steer = offset_steer(longint'(lct_pkg::GAIN_HIGH), wsum, sum);
        if (pred_age > cfg_corner_out) switch_mode(lct_pkg::MODE_FOLLOW);
      end
      lct_pkg::MODE_RIGHT_DETECT, lct_pkg::MODE_LEFT_DETECT: begin
        steer = offset_steer(longint'(lct_pkg::GAIN_LOW), wsum, sum);
        if (dark == 0)
          switch_mode((pred_mode == lct_pkg::MODE_RIGHT_DETECT) ? lct_pkg::MODE_RIGHT_TURN
                                                                : lct_pkg::MODE_LEFT_TURN);
        if (pred_age > cfg_timeout) switch_mode(lct_pkg::MODE_FOLLOW);
      end
      lct_pkg::MODE_RIGHT_TURN: begin
        steer = (pred_age < cfg_hold) ? -longint'(lct_pkg::STEER_HARD)
                                      : longint'(lct_pkg::STEER_SOFT);
        if (dark > lct_pkg::TURN_EXIT_DARK) switch_mode(lct_pkg::MODE_FOLLOW);
      end
      lct_pkg::MODE_LEFT_TURN: begin
        steer = (pred_age < cfg_hold) ? longint'(lct_pkg::STEER_HARD)
                                      : -longint'(lct_pkg::STEER_SOFT);
        if (dark > lct_pkg::TURN_EXIT_DARK) switch_mode(lct_pkg::MODE_FOLLOW);
      end
      default: begin
        steer = offset_steer(longint'(lct_pkg::GAIN_HIGH), wsum, sum);
        if (dark > cfg_corner) switch_mode(lct_pkg::MODE_CORNER_IN);
        else if (gap_ok && right_dark > cfg_change) switch_mode(lct_pkg::MODE_RIGHT_DETECT);
        else if (gap_ok && left_dark > cfg_change) switch_mode(lct_pkg::MODE_LEFT_DETECT);
      end
    endcase
    res.steer = lct_pkg::STEER_W'(steer);
    return res;
  endfunction

  function automatic logic [lct_pkg::SAMPLE_W-1:0] dark_sample();
    if (cfg_thr == 0) return '0;
    return lct_pkg::SAMPLE_W'($urandom_range(cfg_thr - 1, 0));
  endfunction

  function automatic logic [lct_pkg::SAMPLE_W-1:0] bright_sample();
    return lct_pkg::SAMPLE_W'($urandom_range(1023, cfg_thr));
  endfunction

  function automatic tick_samples_t make_tick(input tick_kind_e kind);
    tick_samples_t t;
    int p;
    p = $urandom_range(lct_pkg::NUM_SENSORS - 1, 0);
    foreach (t[i]) t[i] = bright_sample();
    case (kind)
      TK_LINE: begin
        t[p] = dark_sample();
        if (p < lct_pkg::NUM_SENSORS - 1 && $urandom_range(1, 0) == 1) t[p+1] = dark_sample();
      end
      TK_CORNER: foreach (t[i]) t[i] = dark_sample();
      TK_RIGHT_MARK: begin
        for (int i = lct_pkg::NUM_SENSORS / 2; i < lct_pkg::NUM_SENSORS; i++)
          t[i] = dark_sample();
        if ($urandom_range(1, 0) == 1) t[lct_pkg::NUM_SENSORS/2-1] = dark_sample();
      end
      TK_LEFT_MARK: begin
        for (int i = 0; i < lct_pkg::NUM_SENSORS / 2; i++) t[i] = dark_sample();
        if ($urandom_range(1, 0) == 1) t[lct_pkg::NUM_SENSORS/2] = dark_sample();
      end
      TK_EXIT: begin
        if (p > lct_pkg::NUM_SENSORS - 3) p = lct_pkg::NUM_SENSORS - 3;
        for (int i = p; i < p + 3; i++) t[i] = dark_sample();
      end
      TK_NOISE: begin
        foreach (t[i]) begin
          case ($urandom_range(3, 0))
            0: t[i] = '0;
            1: t[i] = '1;
            default: t[i] = lct_pkg::SAMPLE_W'($urandom);
          endcase
        end
      end
      TK_ZERO: t = '0;
      TK_FULL: t = '1;
      default: ;
    endcase
    return t;
  endfunction

  function automatic void push_ticks(input tick_kind_e kind, input int n);
    repeat (n) tick_q.push_back(make_tick(kind));
  endfunction

  // A lap is a stretch of plain line followed by a lane change, a corner,
  // noise, or a broken sequence of random tick shapes.
  function automatic void push_lap();
    int pick;
    pick = $urandom_range(9, 0);
    push_ticks(TK_LINE, capped(cfg_gap, 30) + $urandom_range(4, 1));
    if (pick < 4) begin
      push_ticks(pick[0] ? TK_RIGHT_MARK : TK_LEFT_MARK, $urandom_range(2, 1));
      push_ticks(TK_LINE, $urandom_range(capped(cfg_timeout, 20) + 2, 0));
      push_ticks(TK_BRIGHT, $urandom_range(2, 1));
      push_ticks(TK_LINE, $urandom_range(capped(cfg_hold, 20) + 3, 0));
      push_ticks(TK_EXIT, 1);
    end else if (pick < 7) begin
      push_ticks(TK_CORNER, $urandom_range(2, 1));
      push_ticks(TK_LINE, capped(cfg_gap, 30) + 1);
      push_ticks(pick[0] ? TK_RIGHT_MARK : TK_LEFT_MARK, 1);
      push_ticks(TK_LINE, $urandom_range(capped(cfg_corner_out, 20) + 2, 0));
    end else if (pick < 9) begin
      push_ticks(TK_NOISE, $urandom_range(6, 1));
    end else begin
      repeat ($urandom_range(5, 2)) push_ticks(tick_kind_e'($urandom_range(TK_FULL, 0)), 1);
    end
  endfunction

  function automatic void set_course_reg(input logic [lct_pkg::REG_IDX_W-1:0] idx,
                                         input logic [31:0] val);
    case (idx)
      lct_pkg::REG_DARK_THRESHOLD: cfg_thr = val[lct_pkg::SAMPLE_W-1:0];
      lct_pkg::REG_CORNER_COUNT:   cfg_corner = val[3:0];
      lct_pkg::REG_CHANGE_COUNT:   cfg_change = val[2:0];
      lct_pkg::REG_GAP_TICKS:      cfg_gap = val[AGE_W-1:0];
      lct_pkg::REG_CORNER_OUT:     cfg_corner_out = val[AGE_W-1:0];
      lct_pkg::REG_CHANGE_TIMEOUT: cfg_timeout = val[AGE_W-1:0];
      lct_pkg::REG_TURN_HOLD:      cfg_hold = val[AGE_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic apb_write(input logic [lct_pkg::REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    set_course_reg(idx, val);
  endtask

  task automatic load_config(input int thr, input int corner, input int change,
                             input int gap, input int cout, input int tmo,
                             input int hold);
    apb_write(lct_pkg::REG_DARK_THRESHOLD, thr);
    apb_write(lct_pkg::REG_CORNER_COUNT, corner);
    apb_write(lct_pkg::REG_CHANGE_COUNT, change);
    apb_write(lct_pkg::REG_GAP_TICKS, gap);
    apb_write(lct_pkg::REG_CORNER_OUT, cout);
    apb_write(lct_pkg::REG_CHANGE_TIMEOUT, tmo);
    apb_write(lct_pkg::REG_TURN_HOLD, hold);
  endtask

  task automatic wait_idle(input int settle);
    while (tick_q.size() != 0 || offered_cnt != accepted_cnt || course_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin : drive_ticks
    tick_samples_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (offered_cnt == accepted_cnt) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (tick_q.size() != 0) begin
        nxt = tick_q.pop_front();
        sample_0_i <= nxt[0];
        sample_1_i <= nxt[1];
        sample_2_i <= nxt[2];
        sample_3_i <= nxt[3];
        sample_4_i <= nxt[4];
        sample_5_i <= nxt[5];
        sample_6_i <= nxt[6];
        sample_7_i <= nxt[7];
        in_valid_i <= 1'b1;
        offered_cnt++;
        send_gap = pick_gap(send_idle_pct);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      out_stall_i <= 1'b1;
      hold_left = LONG_HOLD - 1;
      hold_served++;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap(recv_idle_pct);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin : take_ticks
    if (rst_ni && in_valid_i && !in_stall_o) begin
      course_exp_q.push_back(predict_tick({sample_7_i, sample_6_i, sample_5_i, sample_4_i,
                                           sample_3_i, sample_2_i, sample_1_i, sample_0_i}));
      accepted_cnt++;
    end
  end

  always @(posedge clk_i) begin : check_results
    course_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (course_exp_q.size() == 0) begin
        $error("unexpected transaction: drive_speed %0d steer_value %0d mode_out %0d",
               drive_speed_o, steer_value_o, mode_out_o);
        error_cnt++;
      end else begin
        want = course_exp_q.pop_front();
        if (drive_speed_o !== want.speed) begin
          $error("drive_speed: expected %0d, actual %0d", want.speed, drive_speed_o);
          error_cnt++;
        end
        if (steer_value_o !== want.steer) begin
          $error("steer_value: expected %0d, actual %0d", want.steer, steer_value_o);
          error_cnt++;
        end
        if (mode_out_o !== want.mode) begin
          $error("mode_out: expected %0d, actual %0d", want.mode, mode_out_o);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed laps, first on the reset register values.
    send_idle_pct = 20;
    recv_idle_pct = 20;
    push_ticks(TK_ZERO, 1);
    push_ticks(TK_FULL, 1);
    push_ticks(TK_NOISE, 2);
    wait_idle(SETTLE);
    load_config(400, 6, 3, 2, 3, 4, 2);
    push_ticks(TK_LINE, 3);
    push_ticks(TK_RIGHT_MARK, 1);
    push_ticks(TK_LINE, 4);
    push_ticks(TK_LINE, 3);
    push_ticks(TK_RIGHT_MARK, 1);
    push_ticks(TK_BRIGHT, 1);
    push_ticks(TK_LINE, 3);
    push_ticks(TK_EXIT, 1);
    push_ticks(TK_LINE, 3);
    push_ticks(TK_LEFT_MARK, 1);
    push_ticks(TK_BRIGHT, 1);
    push_ticks(TK_EXIT, 1);
    wait_idle(SETTLE);

    send_idle_pct = 30;
    recv_idle_pct = 30;
    load_config(1023, 8, 4, 65535, 65535, 65535, 65535);
    push_ticks(TK_NOISE, 20);
    push_lap();
    wait_idle(SETTLE);
    load_config(0, 0, 0, 0, 0, 0, 0);
    push_ticks(TK_NOISE, 15);
    wait_idle(SETTLE);
    load_config(512, 0, 0, 0, 0, 0, 0);
    repeat (4) push_lap();
    wait_idle(SETTLE);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 2) ? 0 : 30;
      recv_idle_pct = (ph == 2) ? 0 : 30;
      load_config($urandom_range(800, 200), $urandom_range(7, 4), $urandom_range(3, 2),
                  $urandom_range(10, 0), $urandom_range(10, 0), $urandom_range(20, 0),
                  $urandom_range(10, 0));
      while (tick_q.size() < 40) push_lap();
      wait_idle(SETTLE);
    end

    // The receiver holds off for a long stretch while ticks keep coming.
    send_idle_pct = 10;
    recv_idle_pct = 0;
    push_ticks(TK_LINE, 40);
    hold_requests++;
    wait_idle(SETTLE);

    // Walk the course into a right turn, then stay there past the hard
    // steering stretch.
    send_idle_pct = 0;
    load_config(400, 6, 3, 0, 0, 0, 2);
    while (pred_mode != lct_pkg::MODE_RIGHT_TURN) begin
      case (pred_mode)
        lct_pkg::MODE_FOLLOW, lct_pkg::MODE_CORNER_IN: push_ticks(TK_RIGHT_MARK, 1);
        lct_pkg::MODE_RIGHT_DETECT: push_ticks(TK_BRIGHT, 1);
        default: push_ticks(TK_EXIT, 1);
      endcase
      wait_idle(SETTLE);
    end
    push_ticks(TK_LINE, 12);
    push_ticks(TK_EXIT, 1);
    wait_idle(2 * SETTLE);

    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
